>>> sv/dfl_pkg.sv
// dfl_pkg: shared types, constants and table functions for the DFA token lexer.
// Holds the character classes, DFA transitions, token kinds and keyword text.
// No dependencies; every other file of the lexer imports it.
package dfl_pkg;

   // Sizes
   localparam int unsigned KEYWORD_MAX_LEN = 9;
   localparam int unsigned POS_WIDTH       = 16;
   localparam int unsigned NUM_KEYWORDS    = 46;
   localparam int unsigned KW_LEN_W        = $clog2(KEYWORD_MAX_LEN + 1);

   // Result queue sizing
   localparam int unsigned RSP_DEPTH = 4;
   localparam int unsigned RSP_PTR_W = $clog2(RSP_DEPTH);
   localparam int unsigned RSP_CNT_W = $clog2(RSP_DEPTH + 1);

   // Character classes
   localparam logic [3:0] CLS_OTHER   = 4'd0;
   localparam logic [3:0] CLS_DIGIT   = 4'd1;
   localparam logic [3:0] CLS_LETTER  = 4'd2;
   localparam logic [3:0] CLS_COMMA   = 4'd3;
   localparam logic [3:0] CLS_LBR     = 4'd4;
   localparam logic [3:0] CLS_RBR     = 4'd5;
   localparam logic [3:0] CLS_COLON   = 4'd6;
   localparam logic [3:0] CLS_QUOTE   = 4'd7;
   localparam logic [3:0] CLS_BSLASH  = 4'd8;
   localparam logic [3:0] CLS_EOI     = 4'd9;
   localparam logic [3:0] CLS_DOT     = 4'd10;
   localparam logic [3:0] CLS_HASH    = 4'd11;
   localparam logic [3:0] CLS_NEWLINE = 4'd12;

   // DFA states; transition codes above the last state mean stop or fail
   localparam logic [3:0] ST_START    = 4'd0;
   localparam logic [3:0] ST_NUMBER   = 4'd1;
   localparam logic [3:0] ST_IDENT    = 4'd2;
   localparam logic [3:0] ST_COMMA    = 4'd3;
   localparam logic [3:0] ST_LBR      = 4'd4;
   localparam logic [3:0] ST_RBR      = 4'd5;
   localparam logic [3:0] ST_COLON    = 4'd6;
   localparam logic [3:0] ST_STR_BODY = 4'd7;
   localparam logic [3:0] ST_STR_ESC  = 4'd8;
   localparam logic [3:0] ST_STR_DONE = 4'd9;
   localparam logic [3:0] ST_DOT      = 4'd10;
   localparam logic [3:0] ST_COMMENT  = 4'd11;
   localparam logic [3:0] ST_NEWLINE  = 4'd12;
   localparam logic [3:0] NX_STOP     = 4'd13;
   localparam logic [3:0] NX_FAIL     = 4'd14;

   // Token kinds
   localparam logic [5:0] KIND_NUMBER    = 6'd0;
   localparam logic [5:0] KIND_IDENT     = 6'd1;
   localparam logic [5:0] KIND_COMMA     = 6'd2;
   localparam logic [5:0] KIND_LBR       = 6'd3;
   localparam logic [5:0] KIND_RBR       = 6'd4;
   localparam logic [5:0] KIND_COLON     = 6'd5;
   localparam logic [5:0] KIND_STRING    = 6'd6;
   localparam logic [5:0] KIND_DOT       = 6'd7;
   localparam logic [5:0] KIND_COMMENT   = 6'd8;
   localparam logic [5:0] KIND_NEWLINE   = 6'd9;
   localparam logic [5:0] KIND_BADSTRING = 6'd10;
   localparam logic [5:0] KIND_KW_BASE   = 6'd11;
   localparam logic [5:0] KIND_INVALID   = 6'd57;

   // Keyword text, right-justified with zero fill on the left
   localparam logic [8*KEYWORD_MAX_LEN-1:0] KW_TEXT [NUM_KEYWORDS] = '{
      "assign", "add", "sub", "mul", "smul", "div", "sdiv", "rem", "srem",
      "and", "or", "xor", "not", "shl", "ashr", "lshr", "neg", "call", "with",
      "ret", "br", "goto", "cz", "cnz", "ceq", "cne", "cgt", "cgts", "cge",
      "cges", "clt", "clts", "cle", "cles", "variables", "byte", "word",
      "dword", "qword", "float", "double", "pointer", "label", "define",
      "nop", "select"
   };

   // Transaction payloads
   typedef struct packed {
      logic [6:0] ch;
      logic       end_of_input;
   } req_type;

   typedef struct packed {
      logic [5:0]  kind;
      logic [15:0] start_pos;
      logic [15:0] token_len;
      logic        last;
   } rsp_type;

   // Results produced by one character, handed to the result queue
   typedef struct packed {
      logic [1:0]   count;
      rsp_type [1:0] item;
   } push_type;

   // Keyword length: number of non-zero bytes
   function automatic logic [KW_LEN_W-1:0] kw_len(int unsigned k);
      logic [KW_LEN_W-1:0] n;
      n = '0;
      for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
         if (KW_TEXT[k][8*i +: 8] != 8'd0) begin
            n = n + 1'b1;
         end
      end
      return n;
   endfunction

   // Character to class
   function automatic logic [3:0] char_class(logic [6:0] c);
      logic [3:0] cls;
      cls = CLS_OTHER;
      if (c >= 7'h30 && c <= 7'h39) begin
         cls = CLS_DIGIT;
      end else if ((c >= 7'h61 && c <= 7'h7a) || (c >= 7'h41 && c <= 7'h5a) ||
                   c == 7'h5f) begin
         cls = CLS_LETTER;
      end else begin
         case (c)
            7'h2c:   cls = CLS_COMMA;
            7'h5b:   cls = CLS_LBR;
            7'h5d:   cls = CLS_RBR;
            7'h3a:   cls = CLS_COLON;
            7'h22:   cls = CLS_QUOTE;
            7'h5c:   cls = CLS_BSLASH;
            7'h2e:   cls = CLS_DOT;
            7'h23:   cls = CLS_HASH;
            7'h0a:   cls = CLS_NEWLINE;
            default: cls = CLS_OTHER;
         endcase
      end
      return cls;
   endfunction

   // DFA transition
   function automatic logic [3:0] dfa_next(logic [3:0] s, logic [3:0] c);
      logic [3:0] nx;
      nx = NX_STOP;
      case (s)
         ST_START: begin
            if (c == CLS_BSLASH) nx = NX_FAIL;
            else if (c == CLS_OTHER || c == CLS_EOI || c > CLS_NEWLINE) nx = NX_STOP;
            else nx = c;
         end
         ST_NUMBER: begin
            if (c == CLS_DIGIT) nx = ST_NUMBER;
         end
         ST_IDENT: begin
            if (c == CLS_DIGIT || c == CLS_LETTER) nx = ST_IDENT;
         end
         ST_STR_BODY: begin
            if (c <= CLS_COLON) nx = ST_STR_BODY;
            else if (c == CLS_QUOTE) nx = ST_STR_DONE;
            else if (c == CLS_BSLASH) nx = ST_STR_ESC;
            else if (c == CLS_EOI) nx = NX_FAIL;
         end
         ST_STR_ESC: begin
            if (c <= CLS_BSLASH) nx = ST_STR_BODY;
            else if (c == CLS_EOI) nx = NX_FAIL;
         end
         ST_COMMENT: begin
            if (c <= CLS_HASH) nx = ST_COMMENT;
         end
         default: nx = NX_STOP;
      endcase
      return nx;
   endfunction

   // Kind reported by a pending token in a given state (identifier aside)
   function automatic logic [5:0] state_kind(logic [3:0] s);
      logic [5:0] k;
      case (s)
         ST_IDENT:    k = KIND_IDENT;
         ST_COMMA:    k = KIND_COMMA;
         ST_LBR:      k = KIND_LBR;
         ST_RBR:      k = KIND_RBR;
         ST_COLON:    k = KIND_COLON;
         ST_STR_BODY: k = KIND_BADSTRING;
         ST_STR_ESC:  k = KIND_BADSTRING;
         ST_STR_DONE: k = KIND_STRING;
         ST_DOT:      k = KIND_DOT;
         ST_COMMENT:  k = KIND_COMMENT;
         ST_NEWLINE:  k = KIND_NEWLINE;
         default:     k = KIND_NUMBER;
      endcase
      return k;
   endfunction

   // Saturating position increment
   function automatic logic [POS_WIDTH-1:0] sat_inc(logic [POS_WIDTH-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

>>> sv/dfl_core.sv
// dfl_core: input register, DFA and token state, keyword match and result build.
// Depends on dfl_pkg. Feeds up to two results per character into dfl_rsp_fifo.
module dfl_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  dfl_pkg::req_type  req_data,
   input  logic              fifo_room,
   output dfl_pkg::push_type push
);
   import dfl_pkg::*;

   // Input register
   logic    in_valid_ff, in_valid_in;
   req_type in_data_ff;

   // Token state
   logic [3:0]           dfa_state_ff, dfa_state_in;
   logic [POS_WIDTH-1:0] char_pos_ff, char_pos_in;
   logic [POS_WIDTH-1:0] tok_start_ff, tok_start_in;
   logic [POS_WIDTH-1:0] tok_len_ff, tok_len_in;
   logic [6:0]           ident_buf_ff [KEYWORD_MAX_LEN];
   logic [6:0]           ident_buf_in [KEYWORD_MAX_LEN];
   logic                 ident_overflow_ff, ident_overflow_in;

   logic                 fire;
   logic                 req_take;
   logic [5:0]           ident_kind;
   logic [5:0]           pend_kind;
   logic [3:0]           cls;
   logic [3:0]           nx_cur;
   logic [3:0]           nx_start;
   logic                 buf_we;
   logic [POS_WIDTH-1:0] buf_idx;
   logic                 emit_a, emit_b;
   rsp_type              res_a, res_b;

   // Handshake: the input register drains whenever the result queue has room
   assign fire      = in_valid_ff && fifo_room;
   assign req_ready = !in_valid_ff || fire;
   assign req_take  = req_valid && req_ready;
   assign in_valid_in = req_take ? 1'b1 : (fire ? 1'b0 : in_valid_ff);

   // Keyword match against the buffered identifier
   always_comb begin
      logic                         found;
      logic                         match;
      logic [KW_LEN_W-1:0]          len;
      logic [8*KEYWORD_MAX_LEN-1:0] kw_left;
      found      = 1'b0;
      ident_kind = KIND_IDENT;
      for (int k = 0; k < NUM_KEYWORDS; k++) begin
         len     = kw_len(k);
         kw_left = KW_TEXT[k] << (8 * (KEYWORD_MAX_LEN - len));
         match   = (tok_len_ff == POS_WIDTH'(len));
         for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
            if (i < len &&
                ident_buf_ff[i] != kw_left[8*(KEYWORD_MAX_LEN-1-i) +: 7]) begin
               match = 1'b0;
            end
         end
         if (match && !found) begin
            found      = 1'b1;
            ident_kind = 6'(KIND_KW_BASE + k);
         end
      end
      if (ident_overflow_ff || tok_len_ff > POS_WIDTH'(KEYWORD_MAX_LEN)) begin
         ident_kind = KIND_IDENT;
      end
   end

   assign cls       = char_class(in_data_ff.ch);
   assign nx_cur    = dfa_next(dfa_state_ff, in_data_ff.end_of_input ? CLS_EOI : cls);
   assign nx_start  = dfa_next(ST_START, cls);
   assign pend_kind = (dfa_state_ff == ST_IDENT) ? ident_kind : state_kind(dfa_state_ff);

   // One DFA step, with a restart from the start state when the token ends
   always_comb begin
      logic taken;
      taken             = 1'b0;
      dfa_state_in      = dfa_state_ff;
      char_pos_in       = char_pos_ff;
      tok_start_in      = tok_start_ff;
      tok_len_in        = tok_len_ff;
      ident_overflow_in = ident_overflow_ff;
      buf_we            = 1'b0;
      buf_idx           = '0;
      emit_a            = 1'b0;
      emit_b            = 1'b0;
      res_a             = '{kind: pend_kind, start_pos: 16'(tok_start_ff),
                            token_len: 16'(tok_len_ff), last: 1'b0};
      res_b             = '{kind: KIND_INVALID, start_pos: 16'(char_pos_ff),
                            token_len: 16'd0, last: 1'b0};

      if (in_data_ff.end_of_input) begin
         // flush pending token, restart at offset zero
         if (dfa_state_ff != ST_START) begin
            emit_a = 1'b1;
            if (nx_cur != NX_STOP) begin
               res_a.kind      = KIND_INVALID;
               res_a.token_len = 16'd0;
            end
         end
         dfa_state_in      = ST_START;
         tok_start_in      = '0;
         tok_len_in        = '0;
         ident_overflow_in = 1'b0;
         char_pos_in       = '0;
      end else begin
         if (dfa_state_ff != ST_START) begin
            if (nx_cur != NX_STOP && nx_cur != NX_FAIL) begin
               // extend the pending token
               taken = 1'b1;
               if (nx_cur == ST_IDENT) begin
                  if (tok_len_ff < POS_WIDTH'(KEYWORD_MAX_LEN)) begin
                     buf_we  = 1'b1;
                     buf_idx = tok_len_ff;
                  end else begin
                     ident_overflow_in = 1'b1;
                  end
               end
               dfa_state_in = nx_cur;
               tok_len_in   = sat_inc(tok_len_ff);
            end else begin
               // token ends here
               emit_a = 1'b1;
               if (nx_cur == NX_FAIL) begin
                  res_a.kind      = KIND_INVALID;
                  res_a.token_len = 16'd0;
               end
               dfa_state_in      = ST_START;
               tok_start_in      = '0;
               tok_len_in        = '0;
               ident_overflow_in = 1'b0;
            end
         end
         if (!taken) begin
            if (nx_start == NX_FAIL) begin
               emit_b = 1'b1;
            end else if (nx_start != NX_STOP) begin
               dfa_state_in      = nx_start;
               tok_start_in      = char_pos_ff;
               tok_len_in        = POS_WIDTH'(1);
               ident_overflow_in = 1'b0;
               if (nx_start == ST_IDENT) begin
                  buf_we  = 1'b1;
                  buf_idx = '0;
               end
            end
         end
         char_pos_in = sat_inc(char_pos_ff);
      end

      for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
         ident_buf_in[i] = (buf_we && buf_idx == POS_WIDTH'(i)) ? in_data_ff.ch
                                                                 : ident_buf_ff[i];
      end
   end

   // Pack results in order, marking the last one
   always_comb begin
      push = '0;
      if (emit_a && emit_b) begin
         push.count      = 2'd2;
         push.item[0]    = res_a;
         push.item[1]    = res_b;
         push.item[1].last = 1'b1;
      end else if (emit_a) begin
         push.count      = 2'd1;
         push.item[0]    = res_a;
         push.item[0].last = 1'b1;
      end else if (emit_b) begin
         push.count      = 2'd1;
         push.item[0]    = res_b;
         push.item[0].last = 1'b1;
      end
      if (!fire) begin
         push.count = 2'd0;
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff       <= 1'b0;
         dfa_state_ff      <= ST_START;
         char_pos_ff       <= '0;
         tok_start_ff      <= '0;
         tok_len_ff        <= '0;
         ident_overflow_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         if (fire) begin
            dfa_state_ff      <= dfa_state_in;
            char_pos_ff       <= char_pos_in;
            tok_start_ff      <= tok_start_in;
            tok_len_ff        <= tok_len_in;
            ident_overflow_ff <= ident_overflow_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_data_ff <= req_data;
      end
      if (fire) begin
         ident_buf_ff <= ident_buf_in;
      end
   end

endmodule

>>> sv/dfl_rsp_fifo.sv
// dfl_rsp_fifo: small result queue taking up to two results per cycle.
// Depends on dfl_pkg. Drives the rsp_ channel of the lexer top level.
module dfl_rsp_fifo (
   input  logic              clock,
   input  logic              reset,
   input  dfl_pkg::push_type push,
   output logic              fifo_room,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output dfl_pkg::rsp_type  rsp_data
);
   import dfl_pkg::*;

   rsp_type               entry_ff [RSP_DEPTH];
   logic [RSP_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [RSP_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [RSP_CNT_W-1:0]  count_ff, count_in;
   logic [RSP_PTR_W-1:0]  wr_ptr_next;
   logic                  pop;

   // Room for a worst-case character, judged on registered state only
   assign fifo_room   = (count_ff <= RSP_CNT_W'(RSP_DEPTH - 2));
   assign rsp_valid   = (count_ff != '0);
   assign rsp_data    = entry_ff[rd_ptr_ff];
   assign pop         = rsp_valid && rsp_ready;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;

   assign wr_ptr_in = wr_ptr_ff + RSP_PTR_W'(push.count);
   assign rd_ptr_in = rd_ptr_ff + RSP_PTR_W'(pop);
   assign count_in  = count_ff + RSP_CNT_W'(push.count) - RSP_CNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry writes: first result at the write pointer, second one after it
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push.item[0];
      end
      if (push.count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push.item[1];
      end
   end

endmodule

>>> sv/dfa_token_lexer_unit.sv
// dfa_token_lexer_unit: top level of the streaming DFA token lexer.
// Depends on dfl_pkg, dfl_core and dfl_rsp_fifo.
//
//   channel  | direction | payload          | transaction
//   req_     | in        | dfl_pkg::req_type| one character or end-of-input marker
//   rsp_     | out       | dfl_pkg::rsp_type| one token, last flags final of a character
//
// One character is taken every cycle while the result queue has room; both
// results of a two-result character enter the queue together, after the input
// register. The rate is set by the two-entry-per-cycle result queue and its
// single read port. Reset is synchronous and needs no clearing pass. A stalled
// rsp_ side fills the four-entry queue past half, then req_ready drops.
module dfa_token_lexer_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dfl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dfl_pkg::rsp_type rsp_data
);
   import dfl_pkg::*;

   push_type push;
   logic     fifo_room;

   dfl_core u_core (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .fifo_room (fifo_room),
      .push      (push)
   );

   dfl_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .fifo_room (fifo_room),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> tb/tb_top.sv
// tb_top: self-checking testbench for the dfa_token_lexer_unit character lexer.
// Depends on dfl_pkg for the payload types, DFA/class/kind codes and sizes.
`timescale 1ns / 100ps

module tb_top;
   import dfl_pkg::*;

   // Characters the stimulus builds tokens from
   localparam logic [6:0] CH_NEWLINE = 7'h0a;
   localparam logic [6:0] CH_SPACE   = 7'h20;
   localparam logic [6:0] CH_QUOTE   = 7'h22;
   localparam logic [6:0] CH_HASH    = 7'h23;
   localparam logic [6:0] CH_DOT     = 7'h2e;
   localparam logic [6:0] CH_BSLASH  = 7'h5c;
   localparam logic [6:0] CH_DEL     = 7'h7f;

   localparam int RANDOM_ITEMS = 1600;
   localparam int LONG_COMMENT = 200;
   localparam int ERR_PRINTS   = 30;

   typedef struct {
      req_type data;
      bit      drain_first;
   } lex_item_type;

   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   dfa_token_lexer_unit DUT (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

   // Keyword spellings in kind order, starting at KIND_KW_BASE
   string kw_names [0:45] = '{
      "assign", "add", "sub", "mul", "smul", "div", "sdiv", "rem", "srem",
      "and", "or", "xor", "not", "shl", "ashr", "lshr", "neg", "call", "with",
      "ret", "br", "goto", "cz", "cnz", "ceq", "cne", "cgt", "cgts", "cge",
      "cges", "clt", "clts", "cle", "cles", "variables", "byte", "word",
      "dword", "qword", "float", "double", "pointer", "label", "define",
      "nop", "select"
   };

   string ident_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
   string ident_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";
   string str_body   = "abqXYZ0179_,[]: !?-+()*";
   string str_escape = "aZ5_,[]:\"\\ !";
   string punct      = ",[]:.";

   lex_item_type char_q [$];
   rsp_type      tok_exp [$];
   bit           drain_next = 1'b0;
   int           err_count  = 0;

   // Lexer state mirror
   logic [3:0]  lex_state = ST_START;
   logic [15:0] char_pos  = '0;
   logic [15:0] tok_start = '0;
   logic [15:0] tok_len   = '0;
   logic [6:0]  ident_buf [0:KEYWORD_MAX_LEN-1];
   bit          ident_ovf = 1'b0;

   // Driver and monitor bookkeeping
   int           burst_left = 8;
   int           gap_left   = 0;
   bit           send_now;
   lex_item_type next_item;
   rsp_type      exp_tok;
   logic [15:0]  ready_pat = 16'hffff;
   logic [3:0]   pat_idx   = '0;

   // Clock
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
   end

   //--------------------------------------------------------------------------
   // Lexer prediction
   //--------------------------------------------------------------------------

   function automatic logic [3:0] class_of(logic [6:0] c);
      logic [7:0] b;
      logic [3:0] cls;
      b   = {1'b0, c};
      cls = CLS_OTHER;
      if (b >= "0" && b <= "9") begin
         cls = CLS_DIGIT;
      end else if ((b >= "a" && b <= "z") || (b >= "A" && b <= "Z") || b == "_") begin
         cls = CLS_LETTER;
      end else if (b == ",") begin
         cls = CLS_COMMA;
      end else if (b == "[") begin
         cls = CLS_LBR;
      end else if (b == "]") begin
         cls = CLS_RBR;
      end else if (b == ":") begin
         cls = CLS_COLON;
      end else if (c == CH_QUOTE) begin
         cls = CLS_QUOTE;
      end else if (c == CH_BSLASH) begin
         cls = CLS_BSLASH;
      end else if (c == CH_DOT) begin
         cls = CLS_DOT;
      end else if (c == CH_HASH) begin
         cls = CLS_HASH;
      end else if (c == CH_NEWLINE) begin
         cls = CLS_NEWLINE;
      end
      return cls;
   endfunction

   // Next DFA state, or NX_STOP / NX_FAIL
   function automatic logic [3:0] next_of(logic [3:0] s, logic [3:0] cls);
      logic [3:0] nx;
      nx = NX_STOP;
      case (s)
         ST_START: begin
            case (cls)
               CLS_DIGIT:   nx = ST_NUMBER;
               CLS_LETTER:  nx = ST_IDENT;
               CLS_COMMA:   nx = ST_COMMA;
               CLS_LBR:     nx = ST_LBR;
               CLS_RBR:     nx = ST_RBR;
               CLS_COLON:   nx = ST_COLON;
               CLS_QUOTE:   nx = ST_STR_BODY;
               CLS_BSLASH:  nx = NX_FAIL;
               CLS_DOT:     nx = ST_DOT;
               CLS_HASH:    nx = ST_COMMENT;
               CLS_NEWLINE: nx = ST_NEWLINE;
               default:     nx = NX_STOP;
            endcase
         end
         ST_NUMBER: begin
            if (cls == CLS_DIGIT) nx = ST_NUMBER;
         end
         ST_IDENT: begin
            if (cls == CLS_DIGIT || cls == CLS_LETTER) nx = ST_IDENT;
         end
         ST_STR_BODY: begin
            if (cls == CLS_EOI) nx = NX_FAIL;
            else if (cls == CLS_QUOTE) nx = ST_STR_DONE;
            else if (cls == CLS_BSLASH) nx = ST_STR_ESC;
            else if (cls <= CLS_COLON) nx = ST_STR_BODY;
         end
         ST_STR_ESC: begin
            if (cls == CLS_EOI) nx = NX_FAIL;
            else if (cls <= CLS_BSLASH) nx = ST_STR_BODY;
         end
         ST_COMMENT: begin
            // end of input inside a comment is not a stop, so it reports invalid
            if (cls != CLS_NEWLINE) nx = ST_COMMENT;
         end
         default: nx = NX_STOP;
      endcase
      return nx;
   endfunction

   // Exact keyword match; long identifiers never match
   function automatic logic [5:0] ident_kind();
      logic [5:0] k;
      bit         same;
      k = KIND_IDENT;
      if (!ident_ovf && tok_len <= KEYWORD_MAX_LEN) begin
         for (int w = 0; w < NUM_KEYWORDS; w++) begin
            if (kw_names[w].len() == tok_len) begin
               same = 1'b1;
               for (int i = 0; i < tok_len; i++) begin
                  if (kw_names[w][i] != {1'b0, ident_buf[i]}) same = 1'b0;
               end
               if (same) k = KIND_KW_BASE + 6'(w);
            end
         end
      end
      return k;
   endfunction

   function automatic logic [5:0] pending_kind();
      logic [5:0] k;
      case (lex_state)
         ST_IDENT:    k = ident_kind();
         ST_COMMA:    k = KIND_COMMA;
         ST_LBR:      k = KIND_LBR;
         ST_RBR:      k = KIND_RBR;
         ST_COLON:    k = KIND_COLON;
         ST_STR_BODY: k = KIND_BADSTRING;
         ST_STR_ESC:  k = KIND_BADSTRING;
         ST_STR_DONE: k = KIND_STRING;
         ST_DOT:      k = KIND_DOT;
         ST_COMMENT:  k = KIND_COMMENT;
         ST_NEWLINE:  k = KIND_NEWLINE;
         default:     k = KIND_NUMBER;
      endcase
      return k;
   endfunction

   function automatic logic [15:0] pos_inc(logic [15:0] v);
      return (v == 16'hffff) ? v : v + 16'd1;
   endfunction

   function automatic rsp_type tok_rec(logic [5:0] k, logic [15:0] s, logic [15:0] n);
      rsp_type t;
      t.kind      = k;
      t.start_pos = s;
      t.token_len = n;
      t.last      = 1'b0;
      return t;
   endfunction

   // Advance the mirror by one accepted transaction and queue its tokens
   function automatic void lex_step(req_type r);
      rsp_type    out [0:1];
      int         n_out;
      logic [3:0] cls;
      logic [3:0] nx;
      bit         taken;
      n_out = 0;
      if (r.end_of_input) begin
         if (lex_state != ST_START) begin
            nx = next_of(lex_state, CLS_EOI);
            if (nx == NX_STOP) out[n_out] = tok_rec(pending_kind(), tok_start, tok_len);
            else out[n_out] = tok_rec(KIND_INVALID, tok_start, 16'd0);
            n_out++;
         end
         lex_state = ST_START;
         tok_start = '0;
         tok_len   = '0;
         ident_ovf = 1'b0;
         char_pos  = '0;
      end else begin
         cls   = class_of(r.ch);
         taken = 1'b0;
         // try to extend the pending token
         if (lex_state != ST_START) begin
            nx = next_of(lex_state, cls);
            if (nx != NX_STOP && nx != NX_FAIL) begin
               if (nx == ST_IDENT) begin
                  if (tok_len < KEYWORD_MAX_LEN) ident_buf[tok_len] = r.ch;
                  else ident_ovf = 1'b1;
               end
               lex_state = nx;
               tok_len   = pos_inc(tok_len);
               taken     = 1'b1;
            end else begin
               if (nx == NX_STOP) out[n_out] = tok_rec(pending_kind(), tok_start, tok_len);
               else out[n_out] = tok_rec(KIND_INVALID, tok_start, 16'd0);
               n_out++;
               lex_state = ST_START;
               tok_start = '0;
               tok_len   = '0;
               ident_ovf = 1'b0;
            end
         end
         // character not absorbed: rerun it from the start state
         if (!taken) begin
            nx = next_of(ST_START, cls);
            if (nx == NX_FAIL) begin
               out[n_out] = tok_rec(KIND_INVALID, char_pos, 16'd0);
               n_out++;
            end else if (nx != NX_STOP) begin
               lex_state = nx;
               tok_start = char_pos;
               tok_len   = 16'd1;
               ident_ovf = 1'b0;
               if (nx == ST_IDENT) ident_buf[0] = r.ch;
            end
         end
         char_pos = pos_inc(char_pos);
      end
      for (int i = 0; i < n_out; i++) begin
         if (i == n_out - 1) out[i].last = 1'b1;
         tok_exp.insert(tok_exp.size(), out[i]);
      end
   endfunction

   //--------------------------------------------------------------------------
   // Stimulus building
   //--------------------------------------------------------------------------

   task automatic queue_char(input logic [6:0] c);
      lex_item_type it;
      it.data.ch           = c;
      it.data.end_of_input = 1'b0;
      it.drain_first       = drain_next;
      drain_next           = 1'b0;
      char_q.insert(char_q.size(), it);
   endtask

   // ch is random on an end marker, the block ignores it
   task automatic queue_eoi();
      lex_item_type it;
      it.data.ch           = 7'($urandom_range(0, 127));
      it.data.end_of_input = 1'b1;
      it.drain_first       = drain_next;
      drain_next           = 1'b0;
      char_q.insert(char_q.size(), it);
   endtask

   task automatic queue_text(input string s);
      for (int i = 0; i < s.len(); i++) queue_char(7'(s[i]));
   endtask

   function automatic logic [6:0] pick_from(string s);
      return 7'(s[$urandom_range(0, s.len() - 1)]);
   endfunction

   // Any character but newline
   function automatic logic [6:0] comment_char();
      logic [6:0] c;
      c = 7'($urandom_range(0, 127));
      return (c == CH_NEWLINE) ? CH_SPACE : c;
   endfunction

   // One mostly well-formed token, with noise and broken tokens mixed in
   task automatic queue_token();
      int n;
      case ($urandom_range(0, 15))
         0, 1, 2: begin
            queue_text(kw_names[$urandom_range(0, NUM_KEYWORDS - 1)]);
            if ($urandom_range(0, 3) == 0) queue_char(pick_from(ident_tail));
         end
         3, 4: begin
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 13) : $urandom_range(1, 6);
            queue_char(pick_from(ident_head));
            repeat (n - 1) queue_char(pick_from(ident_tail));
         end
         5: begin
            repeat ($urandom_range(1, 6)) queue_char(7'($urandom_range(8'h30, 8'h39)));
         end
         6, 7: queue_char(pick_from(punct));
         8: begin
            queue_char(CH_QUOTE);
            repeat ($urandom_range(0, 6)) begin
               if ($urandom_range(0, 4) == 0) begin
                  queue_char(CH_BSLASH);
                  queue_char(pick_from(str_escape));
               end else begin
                  queue_char(pick_from(str_body));
               end
            end
            // closing quote, or unterminated strings cut by dot, hash, newline or end of input
            case ($urandom_range(0, 7))
               0:       queue_char(CH_DOT);
               1:       queue_char(CH_HASH);
               2:       queue_char(CH_NEWLINE);
               3:       queue_eoi();
               default: queue_char(CH_QUOTE);
            endcase
         end
         9: begin
            queue_char(CH_HASH);
            repeat ($urandom_range(0, 10)) queue_char(comment_char());
            if ($urandom_range(0, 4) == 0) queue_eoi();
            else queue_char(CH_NEWLINE);
         end
         10, 11: queue_char($urandom_range(0, 1) ? CH_SPACE : 7'h09);
         12: queue_char(CH_NEWLINE);
         13: queue_char(7'($urandom_range(0, 127)));
         14: queue_char(CH_BSLASH);
         default: queue_eoi();
      endcase
      if ($urandom_range(0, 1) == 0) queue_char(CH_SPACE);
   endtask

   task automatic queue_random_run(input int count);
      int goal;
      int lines;
      goal  = char_q.size() + count;
      lines = 0;
      while (char_q.size() < goal) begin
         // every few lines the sender waits for the result side to empty
         if (lines % 12 == 11) drain_next = 1'b1;
         repeat ($urandom_range(1, 8)) queue_token();
         queue_char(CH_NEWLINE);
         lines++;
      end
   endtask

   //--------------------------------------------------------------------------
   // Driver: bursts of transactions with random gaps
   //--------------------------------------------------------------------------

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) lex_step(req_data);
         if (!(req_valid && !req_ready)) begin
            send_now = 1'b0;
            if (gap_left != 0) begin
               gap_left--;
            end else if (char_q.size() != 0 &&
                         !(char_q[0].drain_first && tok_exp.size() != 0)) begin
               next_item = char_q.pop_front();
               req_data <= next_item.data;
               send_now  = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left   = $urandom_range(0, 1) ? 0 : $urandom_range(1, 6);
               end
            end
            req_valid <= send_now;
         end
      end
   end

   //--------------------------------------------------------------------------
   // Monitor: receiver stall pattern and token checks
   //--------------------------------------------------------------------------

   task automatic report_mismatch(input string msg);
      if (err_count < ERR_PRINTS) $display("%0t ns: mismatch: %s", $realtime, msg);
      err_count++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ready_pat[pat_idx];
         if (pat_idx == 4'hf) begin
            case ($urandom_range(0, 3))
               0:       ready_pat = 16'hffff;
               1:       ready_pat = 16'($urandom) | 16'h0001;
               2:       ready_pat = 16'($urandom & $urandom) | 16'h0001;
               default: ready_pat = 16'($urandom | $urandom);
            endcase
         end
         pat_idx <= pat_idx + 4'd1;

         if (rsp_valid && rsp_ready) begin
            if (tok_exp.size() == 0) begin
               report_mismatch($sformatf("unexpected token kind %0d start %0d len %0d",
                                         rsp_data.kind, rsp_data.start_pos,
                                         rsp_data.token_len));
            end else begin
               exp_tok = tok_exp.pop_front();
               if (rsp_data.kind != exp_tok.kind)
                  report_mismatch($sformatf("kind %0d, expected %0d",
                                            rsp_data.kind, exp_tok.kind));
               if (rsp_data.start_pos != exp_tok.start_pos)
                  report_mismatch($sformatf("start_pos %0d, expected %0d",
                                            rsp_data.start_pos, exp_tok.start_pos));
               if (rsp_data.token_len != exp_tok.token_len)
                  report_mismatch($sformatf("token_len %0d, expected %0d",
                                            rsp_data.token_len, exp_tok.token_len));
               if (rsp_data.last != exp_tok.last)
                  report_mismatch($sformatf("last %0b, expected %0b",
                                            rsp_data.last, exp_tok.last));
            end
         end
      end
   end

   //--------------------------------------------------------------------------
   // Stimulus and end of run
   //--------------------------------------------------------------------------

   initial begin
      // Directed: skipped extremes, backslash at start, every non-keyword token kind,
      // escaped quote, badstring, end of input in string, comment and idle
      queue_char(7'h00);
      queue_char(CH_DEL);
      queue_char(CH_BSLASH);
      queue_text("9zZ_,[]:\"a\\\"\".#c\n\"x.\"q");
      queue_eoi();
      queue_char(CH_HASH);
      queue_eoi();
      queue_eoi();

      queue_random_run(RANDOM_ITEMS / 2);

      // One long comment, then a short line of mixed tokens
      drain_next = 1'b1;
      queue_eoi();
      queue_char(CH_HASH);
      repeat (LONG_COMMENT) queue_char(comment_char());
      queue_char(CH_NEWLINE);
      queue_text("ab1 42,\"s\" select");

      queue_random_run(RANDOM_ITEMS / 2);
      queue_eoi();

      while (char_q.size() != 0 || req_valid) @(posedge clock);
      while (tok_exp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (err_count == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Run limit
   initial begin
      #40000000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
